[rtl/bns_pkg.sv]
// Shared types and constants for the box suppression block.
package bns_pkg;

	// Largest value of the in-set position counter
	localparam logic [13:0] POS_MAX = 14'd16383;

	// Reset value of the overlap threshold, Q0.16
	localparam logic [15:0] THR_RESET = 16'd29491;

	// Incoming box transaction
	typedef struct packed {
		logic signed [15:0] box_x0;
		logic signed [15:0] box_y0;
		logic        [15:0] box_width;
		logic        [15:0] box_height;
		logic               end_of_set;
	} box_in_t;

	// Outgoing result transaction
	typedef struct packed {
		logic        keep;
		logic [13:0] box_index;
		logic        table_overflow;
		logic        set_done;
	} box_out_t;

	// One kept-table entry as stored in memory
	typedef struct packed {
		logic        [15:0] h;
		logic        [15:0] w;
		logic signed [15:0] y0;
		logic signed [15:0] x0;
	} kept_box_t;

	// Status of the overlap compare pipeline
	typedef struct packed {
		logic busy;
		logic hit_valid;
		logic hit;
	} iou_stat_t;

endpackage

[rtl/bns_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module bns_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/bns_iou.sv]
// Pipelined overlap test of the current box against one kept entry per cycle.
module bns_iou (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_in,
	input  bns_pkg::kept_box_t  entry,
	input  logic [31:0]         entry_area,
	input  bns_pkg::box_in_t    cur,
	input  logic [31:0]         cur_area,
	input  logic [15:0]         thr,
	output bns_pkg::iou_stat_t  stat
);

	// Overlap length of two 1-D spans; zero when they only touch or miss
	function automatic logic [15:0] ovl(input logic signed [15:0] a0,
		input logic [15:0] alen, input logic signed [15:0] b0,
		input logic [15:0] blen);
		logic signed [17:0] a0e, b0e, a1, b1, lo, hi, d;
		a0e = $signed({{2{a0[15]}}, a0});
		b0e = $signed({{2{b0[15]}}, b0});
		a1 = a0e + $signed({2'b00, alen});
		b1 = b0e + $signed({2'b00, blen});
		lo = (a0e > b0e) ? a0e : b0e;
		hi = (a1 < b1) ? a1 : b1;
		d = hi - lo;
		return (hi > lo) ? d[15:0] : 16'd0;
	endfunction

	logic        v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [15:0] ovx_s2, ovy_s2;
	logic [31:0] ka_s2, ka_s3;
	logic [31:0] inter_s3, inter_s4;
	logic [32:0] uni_s4;
	logic [48:0] prod_s5;
	logic [47:0] ish_s5;
	logic        hit_s6;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s2 <= valid_in;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// datapath: overlaps, intersection, union, scaled compare
	always_ff @(posedge clk) begin
		ovx_s2   <= ovl(cur.box_x0, cur.box_width, entry.x0, entry.w);
		ovy_s2   <= ovl(cur.box_y0, cur.box_height, entry.y0, entry.h);
		ka_s2    <= entry_area;
		inter_s3 <= ovx_s2 * ovy_s2;
		ka_s3    <= ka_s2;
		uni_s4   <= {1'b0, cur_area} + {1'b0, ka_s3} - {1'b0, inter_s3};
		inter_s4 <= inter_s3;
		prod_s5  <= {33'd0, thr} * {16'd0, uni_s4};
		ish_s5   <= {inter_s4, 16'd0};
		hit_s6   <= {1'b0, ish_s5} > prod_s5;
	end

	assign stat.busy      = v_s2 | v_s3 | v_s4 | v_s5 | v_s6;
	assign stat.hit_valid = v_s6;
	assign stat.hit       = hit_s6;

endmodule

[rtl/box_nms_suppressor.sv]
// Greedy non-maximum suppression over score-sorted boxes, top level.
//
// Boxes enter on in_valid/in_stall as box_in_t, one at a time; in_stall is
// high while a box is being processed. Each box is compared with every box
// kept so far in its set: the kept table is read one entry per cycle and
// each entry runs through a five-stage overlap compare pipeline. A box is
// scanned against at most MAX_KEPT kept entries and the next box is taken
// only once the current one is decided, so throughput is set by the single
// table read port. Results leave on out_valid/out_stall from an output
// register; the next box is accepted while a result still waits there. If
// the receiver stalls when a new result is ready, the block holds that
// result internally and keeps in_stall high until the output register
// frees. The threshold is written on cfg_valid/cfg_ready (always ready);
// the user must write it only while idle; the block does not enforce it.
// Reset sets the threshold to its default, empties the table and zeroes
// the position counter; table contents need no clearing since only
// entries written in the current set are read. The box marked end_of_set
// clears the table and position counter after its result.
module box_nms_suppressor #(
	parameter int MAX_KEPT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bns_pkg::box_in_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bns_pkg::box_out_t  out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = $clog2(MAX_KEPT + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_KEPT);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DRAIN,
		DECIDE
	} state_t;

	state_t              state_q;
	logic [15:0]         thr_q;
	bns_pkg::box_in_t    cur_q;
	logic [31:0]         area_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rd_idx_q;
	logic [13:0]         pos_q;
	logic                supp_q;
	logic                rv_s1;
	logic                out_free;
	logic                rd_en;
	logic                wr_en;
	logic                keep;
	logic                ovf;
	bns_pkg::kept_box_t  wr_box;
	bns_pkg::kept_box_t  rd_box;
	logic [31:0]         rd_area;
	bns_pkg::iou_stat_t  iou_stat;

	assign in_stall  = (state_q != IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;

	// table access
	assign rd_en = (state_q == SCAN) && (rd_idx_q != count_q);
	assign keep  = !supp_q;
	assign ovf   = keep && (count_q == CNT_FULL);
	assign wr_en = (state_q == DECIDE) && out_free && keep && !ovf;

	assign wr_box.x0 = cur_q.box_x0;
	assign wr_box.y0 = cur_q.box_y0;
	assign wr_box.w  = cur_q.box_width;
	assign wr_box.h  = cur_q.box_height;

	bns_ram #(.WIDTH(64), .DEPTH(MAX_KEPT)) u_box_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_box),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_box)
	);

	bns_ram #(.WIDTH(32), .DEPTH(MAX_KEPT)) u_area_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (area_q),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_area)
	);

	bns_iou u_iou (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (rv_s1),
		.entry      (rd_box),
		.entry_area (rd_area),
		.cur        (cur_q),
		.cur_area   (area_q),
		.thr        (thr_q),
		.stat       (iou_stat)
	);

	// current box and its area, captured on acceptance
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cur_q  <= in_data;
			area_q <= in_data.box_width * in_data.box_height;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == DECIDE && out_free) begin
			out_data.keep           <= keep;
			out_data.box_index      <= pos_q;
			out_data.table_overflow <= ovf;
			out_data.set_done       <= cur_q.end_of_set;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			thr_q     <= bns_pkg::THR_RESET;
			count_q   <= '0;
			rd_idx_q  <= '0;
			pos_q     <= '0;
			supp_q    <= 1'b0;
			rv_s1     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			// result register: load on decide, free once taken
			if (state_q == DECIDE && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (iou_stat.hit_valid && iou_stat.hit) begin
				supp_q <= 1'b1;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						rd_idx_q <= '0;
						supp_q   <= 1'b0;
						state_q  <= SCAN;
					end
				end
				SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (!rv_s1 && !iou_stat.busy) begin
						state_q <= DECIDE;
					end
				end
				DECIDE: begin
					if (out_free) begin
						if (cur_q.end_of_set) begin
							count_q <= '0;
							pos_q   <= '0;
						end else begin
							if (wr_en) begin
								count_q <= count_q + 1'b1;
							end
							if (pos_q != bns_pkg::POS_MAX) begin
								pos_q <= pos_q + 1'b1;
							end
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[sim/tb.sv]
// Self-checking testbench for the greedy box suppression block.
`timescale 1ns / 1ps

module tb;

	localparam int  MAX_KEPT     = 64;
	localparam time CLK_PERIOD   = 20ns;
	localparam int  HOLD_CYCLES  = 400;
	localparam int  ITEMS_PHASE  = 140;
	// ~1.1k boxes, each scanned against at most MAX_KEPT kept entries, plus idle
	// gaps and stalls on both sides; the limit covers the worst case.
	localparam int  LIMIT_CYCLES = 1_000_000;

	// Directed stimulus row; want is used only where typed is set
	typedef struct {
		bns_pkg::box_in_t  b;
		bit                typed;
		bns_pkg::box_out_t want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	bns_pkg::box_in_t  in_data;
	logic              out_valid;
	logic              out_stall;
	bns_pkg::box_out_t out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [15:0]       cfg_data;

	// Shadow suppression state
	bns_pkg::kept_box_t shadow_boxes[MAX_KEPT];
	longint             shadow_areas[MAX_KEPT];
	int                 shadow_count = 0;
	int                 shadow_pos = 0;
	logic [15:0]        shadow_thr = bns_pkg::THR_RESET;

	bns_pkg::box_out_t  awaited_verdicts[$];
	dir_row_t           directed_rows[$];
	int                 mismatch_total = 0;
	bit                 steady_flow = 1'b0;
	int                 holds_asked = 0;

	box_nms_suppressor #(
		.MAX_KEPT(MAX_KEPT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Length of the common part of two 1-D spans, zero when they only touch
	function automatic longint span_overlap(int a0, int alen, int b0, int blen);
		int lo;
		int hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
		return (hi > lo) ? longint'(hi - lo) : 64'sd0;
	endfunction

	// Keep/suppress verdict for one box; updates the shadow table
	function automatic bns_pkg::box_out_t judge_box(bns_pkg::box_in_t b);
		bns_pkg::box_out_t  v;
		bns_pkg::kept_box_t e;
		longint             area;
		longint             inter;
		longint             uni;
		bit                 keep;
		area = longint'(b.box_width) * longint'(b.box_height);
		keep = 1'b1;
		for (int i = 0; i < shadow_count; i++) begin
			e = shadow_boxes[i];
			inter = span_overlap($signed(b.box_x0), b.box_width, $signed(e.x0), e.w) *
				span_overlap($signed(b.box_y0), b.box_height, $signed(e.y0), e.h);
			uni = area + shadow_areas[i] - inter;
			// ratio test without division
			if ((inter << 16) > longint'(shadow_thr) * uni)
				keep = 1'b0;
		end
		v.keep = keep;
		v.table_overflow = 1'b0;
		v.box_index = shadow_pos[13:0];
		v.set_done = b.end_of_set;
		if (keep) begin
			if (shadow_count < MAX_KEPT) begin
				e.x0 = b.box_x0;
				e.y0 = b.box_y0;
				e.w = b.box_width;
				e.h = b.box_height;
				shadow_boxes[shadow_count] = e;
				shadow_areas[shadow_count] = area;
				shadow_count++;
			end else begin
				v.table_overflow = 1'b1;
			end
		end
		if (shadow_pos < int'(bns_pkg::POS_MAX))
			shadow_pos++;
		if (b.end_of_set) begin
			shadow_count = 0;
			shadow_pos = 0;
		end
		return v;
	endfunction

	function automatic void add_row(int x, int y, int w, int h, bit eos, bit typed,
			bit k, int idx);
		dir_row_t r;
		r.b.box_x0 = x[15:0];
		r.b.box_y0 = y[15:0];
		r.b.box_width = w[15:0];
		r.b.box_height = h[15:0];
		r.b.end_of_set = eos;
		r.typed = typed;
		r.want.keep = k;
		r.want.box_index = idx[13:0];
		r.want.table_overflow = 1'b0;
		r.want.set_done = eos;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// One box transaction, with random idle cycles ahead of it
	task automatic send_box(bns_pkg::box_in_t b, bit typed, bns_pkg::box_out_t want);
		bns_pkg::box_out_t v;
		while (!steady_flow && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		v = judge_box(b);
		awaited_verdicts.insert(awaited_verdicts.size(), typed ? want : v);
	endtask

	// Sender goes quiet until every result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_verdicts.size() != 0);
	endtask

	task automatic write_threshold(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_thr = v;
	endtask

	// One score-sorted set: clustered and jittered boxes with some noise,
	// or a grid of disjoint boxes that overruns the kept table
	task automatic send_random_set(bit force_grid, output int n);
		bns_pkg::box_in_t b;
		bns_pkg::box_in_t prev;
		logic [95:0]      raw;
		bit               grid;
		int               kind;
		int               cx;
		int               cy;
		int               w;
		int               h;
		grid = force_grid || ($urandom_range(11) == 0);
		n = grid ? $urandom_range(72, 66) : $urandom_range(40, 1);
		cx = $urandom_range(40000) - 20000;
		cy = $urandom_range(40000) - 20000;
		prev = '0;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(99);
			if (grid) begin
				b.box_x0 = 16'(-16000 + k * 400);
				b.box_y0 = 16'(cy);
				b.box_width = 16'($urandom_range(300, 16));
				b.box_height = 16'($urandom_range(300, 16));
			end else if (kind < 10) begin
				raw = {$urandom, $urandom, $urandom};
				b = raw[64:0];
			end else if (kind < 50 && k > 0) begin
				w = int'(prev.box_width) + $urandom_range(128) - 64;
				h = int'(prev.box_height) + $urandom_range(128) - 64;
				b.box_x0 = prev.box_x0 + 16'($urandom_range(128) - 64);
				b.box_y0 = prev.box_y0 + 16'($urandom_range(128) - 64);
				b.box_width = (w < 0) ? 16'd0 : 16'(w);
				b.box_height = (h < 0) ? 16'd0 : 16'(h);
			end else begin
				b.box_x0 = 16'(cx + $urandom_range(1600) - 800);
				b.box_y0 = 16'(cy + $urandom_range(1600) - 800);
				b.box_width = 16'($urandom_range(1600, 32));
				b.box_height = 16'($urandom_range(1600, 32));
				// degenerate boxes
				if (kind < 58)
					b.box_width = '0;
				else if (kind < 64)
					b.box_height = '0;
			end
			// noise may end the set early
			if (!grid && kind < 10)
				b.end_of_set = ($urandom_range(15) == 0) || (k == n - 1);
			else
				b.end_of_set = (k == n - 1);
			send_box(b, 1'b0, '0);
			prev = b;
		end
	endtask

	function automatic void check_result(bns_pkg::box_out_t got);
		bns_pkg::box_out_t want;
		if (awaited_verdicts.size() == 0) begin
			if (mismatch_total < 10)
				$display("unexpected result: keep=%0b index=%0d overflow=%0b done=%0b",
					got.keep, got.box_index, got.table_overflow, got.set_done);
			mismatch_total++;
			return;
		end
		want = awaited_verdicts.pop_front();
		if (got.keep !== want.keep || got.box_index !== want.box_index ||
				got.table_overflow !== want.table_overflow ||
				got.set_done !== want.set_done) begin
			if (mismatch_total < 10)
				$display("mismatch: exp k=%0b i=%0d o=%0b d=%0b got k=%0b i=%0d o=%0b d=%0b",
					want.keep, want.box_index, want.table_overflow, want.set_done,
					got.keep, got.box_index, got.table_overflow, got.set_done);
			mismatch_total++;
		end
	endfunction

	// Result side: random stalls, a long hold-off on request, checking
	initial begin : result_sink
		int hold_left;
		int holds_served;
		bit stall_next;
		hold_left = 0;
		holds_served = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				check_result(out_data);
			if (holds_served != holds_asked) begin
				holds_served = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				stall_next = !steady_flow && ($urandom_range(99) < 12);
			end
			out_stall <= stall_next;
		end
	end

	// Run limit
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("[box_nms_suppressor] ERROR");
		$finish;
	end

	// Stimulus: directed rows, then threshold phases
	initial begin : stimulus
		int          sent;
		int          n;
		int          n_sets;
		logic [15:0] thr_pick;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;

		// first set: identical, touching, partial, extreme and zero-area boxes
		add_row(0, 0, 160, 160, 0, 1, 1, 0);
		add_row(0, 0, 160, 160, 0, 1, 0, 1);
		add_row(160, 0, 160, 160, 0, 1, 1, 2);
		add_row(80, 0, 160, 160, 0, 0, 0, 0);
		add_row(-32768, -32768, 65535, 65535, 0, 0, 0, 0);
		add_row(32767, 32767, 65535, 65535, 0, 0, 0, 0);
		add_row(5, 5, 0, 0, 0, 0, 0, 0);
		add_row(5, 5, 0, 0, 0, 1, 1, 7);
		add_row(0, 0, 0, 65535, 1, 0, 0, 0);
		// table clears after end of set
		add_row(-1, -1, 32, 32, 0, 1, 1, 0);
		add_row(-1, -1, 32, 32, 1, 1, 0, 1);
		add_row(32767, -32768, 65535, 0, 1, 1, 1, 0);
		add_row(16'h5555, 16'h2AAA, 16'hAAAA, 16'h5555, 0, 0, 0, 0);
		add_row(16'h2AAA, 16'h5555, 16'h5555, 16'hAAAA, 1, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_box(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);

		for (int phase = 0; phase < 5; phase++) begin
			wait_drained();
			case (phase)
				1: thr_pick = 16'h0000;
				2: thr_pick = 16'hFFFF;
				3: thr_pick = 16'($urandom_range(65535));
				default: thr_pick = 16'h8000;
			endcase
			if (phase != 0)
				write_threshold(thr_pick);
			steady_flow = (phase == 2);
			sent = 0;
			n_sets = 0;
			while (sent < ITEMS_PHASE) begin
				send_random_set(phase == 0 && n_sets == 0, n);
				sent += n;
				n_sets++;
				// receiver backs up while boxes keep coming
				if (phase == 1 && n_sets == 1)
					holds_asked++;
				if (phase == 3 && n_sets == 2)
					wait_drained();
			end
		end

		wait_drained();
		repeat (MAX_KEPT + 16) @(posedge clk);
		if (mismatch_total == 0)
			$display("[box_nms_suppressor] OK");
		else
			$display("[box_nms_suppressor] ERROR");
		$finish;
	end

endmodule

[box_nms_suppressor.f]
rtl/bns_pkg.sv
rtl/bns_ram.sv
rtl/bns_iou.sv
rtl/box_nms_suppressor.sv
sim/tb.sv
